[design/hvd_pkg.sv]
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared widths, constants and tables for the haversine distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hvd_pkg;

  // field widths
  localparam int unsigned LAT_W  = 28;
  localparam int unsigned LON_W  = 29;
  localparam int unsigned DIST_W = 31;

  // angle differences and phases
  localparam int unsigned ANG_W  = 30;
  localparam int unsigned PH_W   = 32;
  localparam int unsigned NUM_ANGLES = 4;

  // degrees to phase: divide by 45 through a reciprocal multiply
  localparam int unsigned OFS_W      = 31;
  localparam int unsigned PROD45_W   = 63;
  localparam int unsigned QUO_W      = 26;
  localparam int unsigned REM_W      = 6;
  localparam int unsigned RECIP_SH   = 37;
  localparam logic [31:0] RECIP_45   = 32'd3054198967;
  localparam int unsigned PHASE_DIV  = 45;
  localparam int unsigned PHASE_BIAS = 22;
  localparam logic [31:0] WRAP_OFS   = 32'd754974720;  // 45 * 2^24
  localparam logic [31:0] WRAP_QUO   = 32'd16777216;   // 2^24
  localparam int unsigned PH_LAT     = 4;

  // cordic
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CW = 34;
  localparam int unsigned ZW = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam int unsigned ROT_LANES = 4;
  localparam int unsigned ROT_LAT   = CORDIC_STEPS + 2;
  localparam int unsigned VEC_LAT   = CORDIC_STEPS + 1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // q30 arithmetic
  localparam int unsigned Q_W  = 31;
  localparam logic [Q_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam int unsigned MUL_W = 2 * CW;
  localparam logic signed [MUL_W-1:0] ROUND_Q30 = 68'sd536870912;

  // square root
  localparam int unsigned SQ_W        = 62;
  localparam int unsigned SQRT_STEPS  = 31;
  localparam int unsigned SQRT_LANES  = 2;
  localparam int unsigned SQRT_LAT    = SQRT_STEPS + 1;

  // distance scaling: round(4 pi 6371 * 2^16)
  localparam int unsigned DPROD_W = 64;
  localparam logic [32:0] FOUR_PI_R = 33'd5246834913;

  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 33'sd536870912;
      1:  v = 33'sd316933406;
      2:  v = 33'sd167458907;
      3:  v = 33'sd85004756;
      4:  v = 33'sd42667331;
      5:  v = 33'sd21354465;
      6:  v = 33'sd10679838;
      7:  v = 33'sd5340245;
      8:  v = 33'sd2670163;
      9:  v = 33'sd1335087;
      10: v = 33'sd667544;
      11: v = 33'sd333772;
      12: v = 33'sd166886;
      13: v = 33'sd83443;
      14: v = 33'sd41722;
      15: v = 33'sd20861;
      16: v = 33'sd10430;
      17: v = 33'sd5215;
      18: v = 33'sd2608;
      19: v = 33'sd1304;
      20: v = 33'sd652;
      21: v = 33'sd326;
      22: v = 33'sd163;
      23: v = 33'sd81;
      24: v = 33'sd41;
      25: v = 33'sd20;
      26: v = 33'sd10;
      27: v = 33'sd5;
      28: v = 33'sd3;
      29: v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // q60 product back to q30, floor after adding one half
  function automatic logic signed [CW-1:0] rnd_q30(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-1:0] t;
    t = (p + ROUND_Q30) >>> 30;
    return CW'(t);
  endfunction

endpackage

`default_nettype wire

[design/hvd_phase.sv]
// ----------------------------------------------------------------------------
// hvd_phase
// Converts signed fixed-point degrees to 32-bit binary phase, four lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_phase
  import hvd_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [ANG_W-1:0] angle_i [NUM_ANGLES],
  output logic                    valid_o,
  output logic [PH_W-1:0]         phase_o [NUM_ANGLES]
);

  // phase = floor((a * 2^(SH) + 22) / 45) mod 2^32, split as a = 45 q + r
  localparam int unsigned SH = 29 - ANGLE_FRAC_BITS;

  logic [PH_LAT-1:0]     vld_q;
  logic [OFS_W-1:0]      off_q  [NUM_ANGLES];
  logic [OFS_W-1:0]      off2_q [NUM_ANGLES];
  logic [PROD45_W-1:0]   prod_q [NUM_ANGLES];
  logic [QUO_W-1:0]      quo_q  [NUM_ANGLES];
  logic [REM_W-1:0]      rem_q  [NUM_ANGLES];
  logic [PH_W-1:0]       ph_q   [NUM_ANGLES];
  logic [PH_W-1:0]       frac_tab [2**REM_W];

  for (genvar g = 0; g < 2**REM_W; g++) begin : g_tab
    assign frac_tab[g] = (g < PHASE_DIV) ?
                         PH_W'(((g << SH) + PHASE_BIAS) / PHASE_DIV) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PH_LAT-2:0], valid_i};
    end
  end

  for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_lane
    logic [31:0]      ofs_d;
    logic [QUO_W-1:0] quo_d;
    logic [REM_W-1:0] rem_d;

    // offset by a multiple of 45 so the dividend is never negative
    assign ofs_d = 32'(angle_i[l]) + WRAP_OFS;
    assign quo_d = prod_q[l][PROD45_W-1:RECIP_SH];
    assign rem_d = REM_W'(off2_q[l] - OFS_W'(OFS_W'(quo_d) * OFS_W'(PHASE_DIV)));

    always_ff @(posedge clk_i) begin
      off_q[l]  <= ofs_d[OFS_W-1:0];
      prod_q[l] <= PROD45_W'(off_q[l]) * PROD45_W'(RECIP_45);
      off2_q[l] <= off_q[l];
      quo_q[l]  <= quo_d;
      rem_q[l]  <= rem_d;
      ph_q[l]   <= ((PH_W'(quo_q[l]) - WRAP_QUO) << SH) + frac_tab[rem_q[l]];
    end

    assign phase_o[l] = ph_q[l];
  end

  assign valid_o = vld_q[PH_LAT-1];

endmodule

`default_nettype wire

[design/hvd_rot.sv]
// ----------------------------------------------------------------------------
// hvd_rot
// Rotation cordic, one step per stage: cosine and sine of a phase, four lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_rot
  import hvd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [PH_W-1:0]      phase_i [ROT_LANES],
  output logic                 valid_o,
  output logic signed [CW-1:0] cos_o [ROT_LANES],
  output logic signed [CW-1:0] sin_o [ROT_LANES]
);

  logic [ROT_LAT-1:0]   vld_q;
  logic signed [CW-1:0] x_q [CORDIC_STEPS+1][ROT_LANES];
  logic signed [CW-1:0] y_q [CORDIC_STEPS+1][ROT_LANES];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS+1][ROT_LANES];
  logic [1:0]           quad_q [CORDIC_STEPS+1][ROT_LANES];
  logic signed [CW-1:0] cos_q [ROT_LANES];
  logic signed [CW-1:0] sin_q [ROT_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ROT_LAT-2:0], valid_i};
    end
  end

  for (genvar l = 0; l < ROT_LANES; l++) begin : g_lane
    logic [1:0]      quad_d;
    logic [PH_W-1:0] red_d;

    // fold into [-45, 45] degrees and remember the quadrant
    assign quad_d = 2'((phase_i[l] + 32'h2000_0000) >> 30);
    assign red_d  = phase_i[l] - {quad_d, 30'b0};

    always_ff @(posedge clk_i) begin
      x_q[0][l]    <= CORDIC_GAIN_INV;
      y_q[0][l]    <= '0;
      z_q[0][l]    <= ZW'(signed'(red_d));
      quad_q[0][l] <= quad_d;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clk_i) begin
        if (!z_q[i][l][ZW-1]) begin
          x_q[i+1][l] <= x_q[i][l] - (y_q[i][l] >>> i);
          y_q[i+1][l] <= y_q[i][l] + (x_q[i][l] >>> i);
          z_q[i+1][l] <= z_q[i][l] - atan_tab(i);
        end else begin
          x_q[i+1][l] <= x_q[i][l] + (y_q[i][l] >>> i);
          y_q[i+1][l] <= y_q[i][l] - (x_q[i][l] >>> i);
          z_q[i+1][l] <= z_q[i][l] + atan_tab(i);
        end
        quad_q[i+1][l] <= quad_q[i][l];
      end
    end

    always_ff @(posedge clk_i) begin
      case (quad_q[CORDIC_STEPS][l])
        QUAD_0: begin
          cos_q[l] <= x_q[CORDIC_STEPS][l];
          sin_q[l] <= y_q[CORDIC_STEPS][l];
        end
        QUAD_1: begin
          cos_q[l] <= -y_q[CORDIC_STEPS][l];
          sin_q[l] <= x_q[CORDIC_STEPS][l];
        end
        QUAD_2: begin
          cos_q[l] <= -x_q[CORDIC_STEPS][l];
          sin_q[l] <= -y_q[CORDIC_STEPS][l];
        end
        default: begin
          cos_q[l] <= y_q[CORDIC_STEPS][l];
          sin_q[l] <= -x_q[CORDIC_STEPS][l];
        end
      endcase
    end

    assign cos_o[l] = cos_q[l];
    assign sin_o[l] = sin_q[l];
  end

  assign valid_o = vld_q[ROT_LAT-1];

endmodule

`default_nettype wire

[design/hvd_sqrt.sv]
// ----------------------------------------------------------------------------
// hvd_sqrt
// Pipelined bit-by-bit integer square root of q30 values shifted to q60.
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_sqrt
  import hvd_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [Q_W-1:0] rad_i  [SQRT_LANES],
  output logic           valid_o,
  output logic [Q_W-1:0] root_o [SQRT_LANES]
);

  logic [SQRT_LAT-1:0] vld_q;
  logic [SQ_W-1:0]     n_q [SQRT_STEPS+1][SQRT_LANES];
  logic [SQ_W-1:0]     r_q [SQRT_STEPS+1][SQRT_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SQRT_LAT-2:0], valid_i};
    end
  end

  for (genvar l = 0; l < SQRT_LANES; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      n_q[0][l] <= SQ_W'({rad_i[l], 30'b0});
      r_q[0][l] <= '0;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [SQ_W-1:0] BitK = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SQ_W-1:0] trial_d;

      assign trial_d = r_q[k][l] + BitK;

      always_ff @(posedge clk_i) begin
        if (n_q[k][l] >= trial_d) begin
          n_q[k+1][l] <= n_q[k][l] - trial_d;
          r_q[k+1][l] <= (r_q[k][l] >> 1) + BitK;
        end else begin
          n_q[k+1][l] <= n_q[k][l];
          r_q[k+1][l] <= r_q[k][l] >> 1;
        end
      end
    end

    assign root_o[l] = r_q[SQRT_STEPS][l][Q_W-1:0];
  end

  assign valid_o = vld_q[SQRT_LAT-1];

endmodule

`default_nettype wire

[design/hvd_vec.sv]
// ----------------------------------------------------------------------------
// hvd_vec
// Vectoring cordic, one step per stage: phase of the vector (x, y).
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_vec
  import hvd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [Q_W-1:0]       x_i,
  input  logic [Q_W-1:0]       y_i,
  output logic                 valid_o,
  output logic signed [ZW-1:0] z_o
);

  logic [VEC_LAT-1:0]   vld_q;
  logic signed [CW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VEC_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= CW'(x_i);
    y_q[0] <= CW'(y_i);
    z_q[0] <= '0;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic pos_d;

    // rotate toward the x axis; zero counts as not above it
    assign pos_d = !y_q[i][CW-1] && (y_q[i] != '0);

    always_ff @(posedge clk_i) begin
      if (pos_d) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_tab(i);
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_tab(i);
      end
    end
  end

  assign valid_o = vld_q[VEC_LAT-1];
  assign z_o     = z_q[CORDIC_STEPS];

endmodule

`default_nettype wire

[design/haversine_distance_top.sv]
// ----------------------------------------------------------------------------
// haversine_distance_top
// Great-circle distance of two points by the haversine formula, pipelined.
// ----------------------------------------------------------------------------
// Takes one point pair per clock whenever start is high; busy is never
// raised. Each item comes out on distance_km_o with done_o high for one
// cycle, in input order. The three cordic and square-root chains each
// take one step per stage. The stages, in order, are degree to phase
// conversion, sine/cosine, products and clamping, square roots, arcsine
// and scaling. The receiver cannot stall the pipeline, so it must take
// every result in the cycle it appears.
`default_nettype none

module haversine_distance_top
  import hvd_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 20,
  parameter int unsigned DIST_FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [LAT_W-1:0] lat_a_i,
  input  logic signed [LON_W-1:0] lon_a_i,
  input  logic signed [LAT_W-1:0] lat_b_i,
  input  logic signed [LON_W-1:0] lon_b_i,
  output logic                    done_o,
  output logic [DIST_W-1:0]       distance_km_o
);

  localparam int unsigned HS_W = CW + 1;
  localparam int unsigned TOTAL_LAT = PH_LAT + ROT_LAT + 3 + SQRT_LAT + VEC_LAT + 3;

  logic signed [ANG_W-1:0] angle_d [NUM_ANGLES];
  logic                    ph_vld;
  logic [PH_W-1:0]         ph     [NUM_ANGLES];
  logic [PH_W-1:0]         rot_ph [NUM_ANGLES];
  logic                    rot_vld;
  logic signed [CW-1:0]    cos_v  [ROT_LANES];
  logic signed [CW-1:0]    sin_v  [ROT_LANES];

  logic                    m1_vld_q, m2_vld_q, m3_vld_q;
  logic signed [CW-1:0]    u2_q, v2_q, pc_q, u2b_q, t_q;
  logic signed [HS_W-1:0]  hsum_d;
  logic [Q_W-1:0]          h_d, h_q, hc_q;
  logic [Q_W-1:0]          rad   [SQRT_LANES];
  logic [Q_W-1:0]          root  [SQRT_LANES];
  logic                    sq_vld;
  logic                    vec_vld;
  logic signed [ZW-1:0]    z_v;

  logic                    d1_vld_q, d2_vld_q, d3_vld_q;
  logic [Q_W-1:0]          zc_d, zc_q;
  logic [DPROD_W-1:0]      dprod_q, dsum_d, dsh_d;
  logic [DIST_W-1:0]       dist_d, dist_q;

  // the pipeline never stalls
  assign busy = 1'b0;

  assign angle_d[0] = ANG_W'(lat_a_i);
  assign angle_d[1] = ANG_W'(lat_b_i);
  assign angle_d[2] = ANG_W'(lat_b_i) - ANG_W'(lat_a_i);
  assign angle_d[3] = ANG_W'(lon_b_i) - ANG_W'(lon_a_i);

  hvd_phase #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .angle_i (angle_d),
    .valid_o (ph_vld),
    .phase_o (ph)
  );

  // differences use half angles
  assign rot_ph[0] = ph[0];
  assign rot_ph[1] = ph[1];
  assign rot_ph[2] = ph[2] >> 1;
  assign rot_ph[3] = ph[3] >> 1;

  hvd_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph_vld),
    .phase_i (rot_ph),
    .valid_o (rot_vld),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
      d3_vld_q <= 1'b0;
    end else begin
      m1_vld_q <= rot_vld;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
      d1_vld_q <= vec_vld;
      d2_vld_q <= d1_vld_q;
      d3_vld_q <= d2_vld_q;
    end
  end

  // h = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2)
  assign hsum_d = HS_W'(u2b_q) + HS_W'(t_q);

  always_comb begin
    if (hsum_d[HS_W-1]) begin
      h_d = '0;
    end else if (hsum_d > HS_W'(Q30_ONE)) begin
      h_d = Q30_ONE;
    end else begin
      h_d = Q_W'(hsum_d);
    end
  end

  always_ff @(posedge clk_i) begin
    u2_q  <= rnd_q30(MUL_W'(sin_v[2]) * MUL_W'(sin_v[2]));
    v2_q  <= rnd_q30(MUL_W'(sin_v[3]) * MUL_W'(sin_v[3]));
    pc_q  <= rnd_q30(MUL_W'(cos_v[0]) * MUL_W'(cos_v[1]));
    t_q   <= rnd_q30(MUL_W'(pc_q) * MUL_W'(v2_q));
    u2b_q <= u2_q;
    h_q   <= h_d;
    hc_q  <= Q30_ONE - h_d;
  end

  assign rad[0] = h_q;
  assign rad[1] = hc_q;

  hvd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m3_vld_q),
    .rad_i   (rad),
    .valid_o (sq_vld),
    .root_o  (root)
  );

  // asin(sqrt(h)) as the phase of (sqrt(1 - h), sqrt(h))
  hvd_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .x_i     (root[1]),
    .y_i     (root[0]),
    .valid_o (vec_vld),
    .z_o     (z_v)
  );

  always_comb begin
    if (z_v[ZW-1]) begin
      zc_d = '0;
    end else if (z_v > ZW'(Q30_ONE)) begin
      zc_d = Q30_ONE;
    end else begin
      zc_d = Q_W'(z_v);
    end
  end

  assign dsum_d = dprod_q + (DPROD_W'(1) << (47 - DIST_FRAC_BITS));
  assign dsh_d  = dsum_d >> (48 - DIST_FRAC_BITS);
  assign dist_d = (|dsh_d[DPROD_W-1:DIST_W]) ? '1 : dsh_d[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    zc_q    <= zc_d;
    dprod_q <= DPROD_W'(zc_q) * DPROD_W'(FOUR_PI_R);
    dist_q  <= dist_d;
  end

  assign done_o        = d3_vld_q;
  assign distance_km_o = dist_q;

`ifndef SYNTHESIS
  // every result goes back to an earlier item taken on start
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, TOTAL_LAT))
    else $error("result without matching item");

  // both square-root radicands always add up to one
  a_radicand : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m3_vld_q |-> ((32'(h_q) + 32'(hc_q)) == 32'(Q30_ONE)))
    else $error("radicands do not sum to one");

  // the arcsine phase reaching the scaler stays within a quarter turn
  a_zrange : assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vld_q |-> (dprod_q <= (DPROD_W'(Q30_ONE) * DPROD_W'(FOUR_PI_R))))
    else $error("distance product out of range");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks the haversine distance pipeline against a bit-true fixed-point
// predictor. A directed table of points is followed by random point pairs,
// with phases of random sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import hvd_pkg::*;

  localparam int unsigned ANG_FRAC  = 20;
  localparam int unsigned DST_FRAC  = 16;
  localparam int unsigned N_RANDOM  = 1040;
  localparam int unsigned N_PHASES  = 4;
  localparam int unsigned N_DIRECTED = 20;
  localparam int unsigned END_WAIT  = 130;
  localparam longint      TURN_Q30  = longint'(1) << 30;
  localparam longint      GAIN_INV  = 652032874;
  localparam longint      FOUR_PI_R_Q16 = 64'd5246834913;

  typedef struct {
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;
  } point_pair_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic signed [LAT_W-1:0] lat_a_i;
  logic signed [LON_W-1:0] lon_a_i;
  logic signed [LAT_W-1:0] lat_b_i;
  logic signed [LON_W-1:0] lon_b_i;
  logic                    done_o;
  logic [DIST_W-1:0]       distance_km_o;

  logic [DIST_W-1:0] dist_expected_q[$];
  int unsigned       mismatch_cnt;
  int unsigned       result_cnt;
  int unsigned       item_cnt;

  haversine_distance_top #(
    .ANGLE_FRAC_BITS (ANG_FRAC),
    .DIST_FRAC_BITS  (DST_FRAC)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .lat_a_i       (lat_a_i),
    .lon_a_i       (lon_a_i),
    .lat_b_i       (lat_b_i),
    .lon_b_i       (lon_b_i),
    .done_o        (done_o),
    .distance_km_o (distance_km_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint arc_atan(input int i);
    return longint'(atan_tab(i));
  endfunction

  function automatic logic [31:0] deg_to_turn(input longint deg);
    longint full;
    longint m;
    longint unsigned q;
    full = longint'(360) << ANG_FRAC;
    m = deg % full;
    if (m < 0) begin
      m += full;
    end
    q = ((longint'(m) << (32 - ANG_FRAC)) + 180) / 360;
    return q[31:0];
  endfunction

  function automatic void turn_sincos(input logic [31:0] ph, output longint c,
                                      output longint s);
    logic [31:0] quad;
    logic [31:0] ru;
    longint      x, y, z, dx, dy;
    quad = ((ph + 32'h2000_0000) >> 30) & 32'd3;
    ru = ph - (quad << 30);
    z = longint'($signed(ru));
    x = GAIN_INV;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_atan(i);
      end else begin
        x += dx; y -= dy; z += arc_atan(i);
      end
    end
    case (quad[1:0])
      QUAD_0: begin c = x;  s = y;  end
      QUAD_1: begin c = -y; s = x;  end
      QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) begin
      b >>= 2;
    end
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(input longint y, input longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arc_atan(i);
      end else begin
        x -= dx; y += dy; z -= arc_atan(i);
      end
    end
    return z;
  endfunction

  function automatic logic [DIST_W-1:0] great_circle_km(input point_pair_t p);
    longint          la, oa, lb, ob;
    longint          ca, sa, cb, sb, cu, u, cv, v, h, z;
    longint unsigned sn, cs, d;
    la = longint'(p.lat_a);
    oa = longint'(p.lon_a);
    lb = longint'(p.lat_b);
    ob = longint'(p.lon_b);
    turn_sincos(deg_to_turn(la), ca, sa);
    turn_sincos(deg_to_turn(lb), cb, sb);
    // half angles: only squares are used, so the phase shift is enough
    turn_sincos(deg_to_turn(lb - la) >> 1, cu, u);
    turn_sincos(deg_to_turn(ob - oa) >> 1, cv, v);
    h = q30_mul(u, u) + q30_mul(q30_mul(ca, cb), q30_mul(v, v));
    if (h < 0) begin
      h = 0;
    end
    if (h > TURN_Q30) begin
      h = TURN_Q30;
    end
    sn = floor_sqrt(longint'(h) << 30);
    cs = floor_sqrt(longint'(TURN_Q30 - h) << 30);
    z = vector_angle(longint'(sn), longint'(cs));
    if (z < 0) begin
      z = 0;
    end
    if (z > TURN_Q30) begin
      z = TURN_Q30;
    end
    d = (longint'(z) * FOUR_PI_R_Q16 + (longint'(1) << (47 - DST_FRAC)))
        >> (48 - DST_FRAC);
    if (d > 64'h7FFF_FFFF) begin
      d = 64'h7FFF_FFFF;
    end
    return d[DIST_W-1:0];
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_cnt++;
      if (dist_expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result: distance_km %0d", distance_km_o);
        end
      end else begin
        logic [DIST_W-1:0] want;
        want = dist_expected_q.pop_front();
        if (want !== distance_km_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: distance_km expected %0d got %0d", want, distance_km_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [LAT_W-1:0] deg_lat(input int deg);
    return LAT_W'(deg * (1 << ANG_FRAC));
  endfunction

  function automatic logic signed [LON_W-1:0] deg_lon(input int deg);
    return LON_W'(deg * (1 << ANG_FRAC));
  endfunction

  // drive one item and hold it until taken
  task automatic send_pair(input point_pair_t p);
    lat_a_i <= p.lat_a;
    lon_a_i <= p.lon_a;
    lat_b_i <= p.lat_b;
    lon_b_i <= p.lon_b;
    start   <= 1'b1;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    dist_expected_q.insert(dist_expected_q.size(), great_circle_km(p));
    item_cnt++;
  endtask

  function automatic point_pair_t random_pair();
    point_pair_t p;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      // whole field, out-of-range values included
      p.lat_a = LAT_W'($urandom);
      p.lon_a = LON_W'($urandom);
      p.lat_b = LAT_W'($urandom);
      p.lon_b = LON_W'($urandom);
    end else begin
      p.lat_a = LAT_W'($signed($urandom_range(0, 188743680)) - 94371840);
      p.lon_a = LON_W'($signed($urandom_range(0, 377487360)) - 188743680);
      if (pick < 3) begin
        // nearby point: small differences
        p.lat_b = p.lat_a + LAT_W'($signed($urandom_range(0, 2048)) - 1024);
        p.lon_b = p.lon_a + LON_W'($signed($urandom_range(0, 2048)) - 1024);
      end else begin
        p.lat_b = LAT_W'($signed($urandom_range(0, 188743680)) - 94371840);
        p.lon_b = LON_W'($signed($urandom_range(0, 377487360)) - 188743680);
      end
    end
    return p;
  endfunction

  initial begin
    point_pair_t dir_tab [N_DIRECTED];
    point_pair_t p;
    int unsigned gap_pct;
    int unsigned waited;

    start   <= 1'b0;
    lat_a_i <= '0;
    lon_a_i <= '0;
    lat_b_i <= '0;
    lon_b_i <= '0;
    rst_ni  = 1'b0;
    mismatch_cnt = 0;
    result_cnt = 0;
    item_cnt = 0;

    // lat_a, lon_a, lat_b, lon_b
    dir_tab = '{
      '{deg_lat(0), deg_lon(0), deg_lat(0), deg_lon(0)},
      '{deg_lat(0), deg_lon(0), deg_lat(0), deg_lon(180)},
      '{deg_lat(90), deg_lon(0), deg_lat(-90), deg_lon(0)},
      '{deg_lat(90), deg_lon(-180), deg_lat(90), deg_lon(180)},
      '{deg_lat(-90), deg_lon(0), deg_lat(0), deg_lon(90)},
      '{deg_lat(45), deg_lon(-180), deg_lat(-45), deg_lon(0)},
      '{deg_lat(0), deg_lon(-180), deg_lat(0), deg_lon(180)},
      '{deg_lat(0), deg_lon(0), deg_lat(0), 29'sd1},
      '{28'sd1, deg_lon(0), deg_lat(0), deg_lon(0)},
      // beyond the poles: cosine turns negative
      '{deg_lat(100), deg_lon(10), deg_lat(-100), deg_lon(170)},
      '{deg_lat(120), deg_lon(0), deg_lat(60), deg_lon(180)},
      // field extremes
      '{28'sh800_0000, 29'sh1000_0000, 28'sh7FF_FFFF, 29'sh0FFF_FFFF},
      '{28'sh7FF_FFFF, 29'sh0FFF_FFFF, 28'sh800_0000, 29'sh1000_0000},
      '{28'sh7FF_FFFF, 29'sh1000_0000, 28'sh7FF_FFFF, 29'sh1000_0000},
      '{28'sh5A0_0000, 29'sh0B40_0000, 28'shA60_0000, 29'sh14C0_0000},
      // longitude wrapping past a full turn
      '{deg_lat(30), deg_lon(200), deg_lat(30), deg_lon(-160)},
      '{deg_lat(10), deg_lon(-250), deg_lat(-10), deg_lon(250)},
      // near-antipodal pairs where h brushes one
      '{deg_lat(45), deg_lon(0), deg_lat(-45), deg_lon(180)},
      '{28'sd1, deg_lon(0), -28'sd1, deg_lon(180)},
      '{deg_lat(89), deg_lon(90), deg_lat(-89), deg_lon(-90)}
    };

    repeat (10) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_pair(dir_tab[i]);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: gap_pct = 0;
        1: gap_pct = 51;
        2: gap_pct = 0;
        default: gap_pct = 20;
      endcase
      for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
        while ($urandom_range(0, 99) < gap_pct) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
        p = random_pair();
        send_pair(p);
      end
    end
    start <= 1'b0;

    waited = 0;
    while (dist_expected_q.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (END_WAIT) @(posedge clk_i);

    $display("covered %0d point pairs, %0d distances seen, %0d mismatches",
             item_cnt, result_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && dist_expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (dist_expected_q.size() != 0) begin
        $display("%0d distances never arrived", dist_expected_q.size());
      end
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/hvd_pkg.sv
design/hvd_phase.sv
design/hvd_rot.sv
design/hvd_sqrt.sv
design/hvd_vec.sv
design/haversine_distance_top.sv
verif/tb_top.sv
